@@ src/caracc_pkg.sv @@
// Shared types and fixed constants for the C-alpha region accumulator.
package caracc_pkg;

	localparam int REGION_W   = 11;
	localparam int CNT_W      = 18;
	localparam int ALPHA_FRAC = 24;
	localparam int PROD_W     = CNT_W + ALPHA_FRAC;   // n*alpha and |d| both stay below 2^42
	localparam int LIM_W      = 21;                   // wide enough for any allele limit
	localparam int DIV_STEPS  = ALPHA_FRAC;           // one quotient bit per cycle
	localparam int MUL_STEPS  = PROD_W / 2;           // radix-4 digits of the multiplier
	localparam int STEP_W     = 5;
	localparam int STAT_W     = 64;
	localparam int TERM_W     = 54;
	localparam int OUT_LO     = 32;                   // products are taken >> 32

	localparam logic MODE_ACC = 1'b0;
	localparam logic MODE_CLR = 1'b1;

	localparam logic signed [STAT_W-1:0] STAT_MAX = {1'b0, {(STAT_W-1){1'b1}}};
	localparam logic signed [STAT_W-1:0] STAT_MIN = {1'b1, {(STAT_W-1){1'b0}}};

	typedef struct packed {
		logic                mode;
		logic [REGION_W-1:0] region;
		logic [CNT_W-1:0]    minor_total;
		logic [CNT_W-1:0]    allele_total;
		logic [CNT_W-1:0]    group_minor;
		logic [CNT_W-1:0]    group_other;
	} in_word_t;

	typedef struct packed {
		logic signed [STAT_W-1:0] region_statistic;
		logic                     saturated;
	} out_word_t;

endpackage

@@ src/c_alpha_region_accumulator_core.sv @@
// C-alpha region accumulator: bit-serial alpha divider, radix-4 serial multipliers, region store.
//
// Usage notes
//   Input channel (item_valid / item_stall / item): one word per variant and group.
//   A word is taken when item_valid is high and item_stall is low. The block
//   works on one word at a time; item_stall stays high while it is busy.
//   Output channel (result_valid / result_stall / result): exactly one word per
//   input word, in order. The result sits in an output register, so a stalled
//   receiver only holds the engine once it has the next result ready.
//   Sequence: an accumulate word runs through the restoring divider (one alpha
//   bit per cycle, n*alpha built alongside), then |d| and 1-alpha, then the 3x
//   multiples, then 21 radix-4 multiplier steps (both products in parallel),
//   then the term, then the saturating add and store write-back. The next word
//   is taken after the result. A clear word or a word with a region outside
//   1..NUM_REGIONS goes straight from acceptance to the write-back step.
//   Reset: asynchronous, active low. Afterwards the store is swept to zero,
//   one entry per cycle over all NUM_REGIONS entries, with item_stall held high.
//   Stall: result_stall holds the output word steady; the engine finishes its
//   current word and waits in its last step until the output register is free.
module c_alpha_region_accumulator_core
	import caracc_pkg::*;
#(
	parameter int NUM_REGIONS = 1024,
	parameter int MAX_ALLELES = 131072
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_word_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result
);

	localparam int IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
	localparam int EXT_W = (IDX_W > REGION_W) ? IDX_W : REGION_W;
	localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_ALLELES);
	localparam logic [ALPHA_FRAC:0] BETA_ONE = {1'b1, {ALPHA_FRAC{1'b0}}};

	// engine states
	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_PREP = 3'd3;
	localparam logic [2:0] ST_TRIP = 3'd4;
	localparam logic [2:0] ST_MUL  = 3'd5;
	localparam logic [2:0] ST_SUM  = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
		clamp_cnt = ({{(LIM_W-CNT_W){1'b0}}, v} > MAX_LIM) ? MAX_LIM[CNT_W-1:0] : v;
	endfunction

	logic [2:0]       state_q;
	logic [IDX_W-1:0] clr_q;
	logic [STEP_W-1:0] cnt_q;

	// item registers
	logic             mode_q;
	logic             hit_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] tot_q;
	logic [CNT_W-1:0] nc_q;
	logic             qz_q;      // total of zero: alpha forced to 0
	logic             qs_q;      // alpha reaches one: forced to all ones

	// divider
	logic [CNT_W-1:0]      r_q;
	logic [ALPHA_FRAC-1:0] alpha_q;
	logic [PROD_W-1:0]     prod_q;

	// two serial multipliers: lane 0 squares |d|, lane 1 forms n*alpha*(1-alpha)
	logic [PROD_W-1:0]   a_q  [2];
	logic [PROD_W+1:0]   a3_q [2];
	logic [PROD_W-1:0]   b_q  [2];
	logic [PROD_W-1:0]   hi_q [2];
	logic [PROD_W-1:0]   lo_q [2];
	logic [PROD_W+1:0]   step_c [2];

	logic signed [TERM_W-1:0] term_q;
	logic signed [STAT_W-1:0] rdata_q;
	logic signed [STAT_W-1:0] mem [NUM_REGIONS];

	out_word_t result_q;
	logic      result_valid_q;

	// input-side combinational
	logic             take;
	logic [CNT_W-1:0] n_c, tot_c, nc_c, mc_c;
	logic [CNT_W:0]   s_c;
	logic             hit_c;
	logic [EXT_W-1:0] idx_ext_c;
	logic [IDX_W-1:0] idx_c;

	// divider step
	logic [CNT_W:0]   r2_c;
	logic [CNT_W:0]   rsub_c;
	logic             ge_c;
	logic             qbit_c;

	// prep
	logic [PROD_W-1:0]     num_c;
	logic [PROD_W-1:0]     mag_c;
	logic [ALPHA_FRAC:0]   beta_c;
	logic [TERM_W-3:0]     sq_c;
	logic [TERM_W-3:0]     var_c;

	// write-back
	logic [STAT_W:0]          sum_c;
	logic signed [STAT_W-1:0] next_c;
	logic                     sat_c;
	logic                     out_free;
	logic                     fin_go;
	logic                     mem_we;
	logic [IDX_W-1:0]         mem_wa;
	logic signed [STAT_W-1:0] mem_wd;

	assign item_stall   = (state_q != ST_IDLE);
	assign take         = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		n_c       = clamp_cnt(item.minor_total);
		tot_c     = clamp_cnt(item.allele_total);
		nc_c      = clamp_cnt(item.group_minor);
		mc_c      = clamp_cnt(item.group_other);
		s_c       = {1'b0, nc_c} + {1'b0, mc_c};
		hit_c     = (item.region != '0) && ({21'd0, item.region} <= 32'(NUM_REGIONS));
		idx_ext_c = EXT_W'(item.region) - EXT_W'(1);
		idx_c     = idx_ext_c[IDX_W-1:0];
	end

	// restoring division, one quotient bit per cycle
	always_comb begin
		r2_c   = {r_q, 1'b0};
		ge_c   = (r2_c >= {1'b0, tot_q});
		rsub_c = r2_c - {1'b0, tot_q};
		if (qz_q) begin
			qbit_c = 1'b0;
		end else if (qs_q) begin
			qbit_c = 1'b1;
		end else begin
			qbit_c = ge_c;
		end
	end

	always_comb begin
		num_c  = {nc_q, {ALPHA_FRAC{1'b0}}};
		mag_c  = (num_c >= prod_q) ? (num_c - prod_q) : (prod_q - num_c);
		beta_c = BETA_ONE - {1'b0, alpha_q};
		sq_c   = {hi_q[0], lo_q[0][PROD_W-1:OUT_LO]};
		var_c  = {hi_q[1], lo_q[1][PROD_W-1:OUT_LO]};
	end

	// radix-4 step: partial product kept below the multiplicand, low digits shift out
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			case (b_q[k][1:0])
				2'd0:    step_c[k] = {2'b00, hi_q[k]};
				2'd1:    step_c[k] = {2'b00, hi_q[k]} + {2'b00, a_q[k]};
				2'd2:    step_c[k] = {2'b00, hi_q[k]} + {1'b0, a_q[k], 1'b0};
				2'd3:    step_c[k] = {2'b00, hi_q[k]} + a3_q[k];
				default: step_c[k] = {2'b00, hi_q[k]};
			endcase
		end
	end

	// saturating add into the region entry
	always_comb begin
		sum_c = {rdata_q[STAT_W-1], rdata_q} + {{(STAT_W+1-TERM_W){term_q[TERM_W-1]}}, term_q};
		sat_c = (sum_c[STAT_W] != sum_c[STAT_W-1]);
		if (!sat_c) begin
			next_c = sum_c[STAT_W-1:0];
		end else if (sum_c[STAT_W]) begin
			next_c = STAT_MIN;
		end else begin
			next_c = STAT_MAX;
		end
	end

	always_comb begin
		out_free = !result_valid_q || !result_stall;
		fin_go   = (state_q == ST_FIN) && out_free;
		mem_we   = (state_q == ST_CLR) || (fin_go && hit_q);
		mem_wa   = (state_q == ST_CLR) ? clr_q : idx_q;
		mem_wd   = ((state_q == ST_CLR) || (mode_q == MODE_CLR)) ? '0 : next_c;
	end

	// region store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (take) begin
			rdata_q <= mem[idx_c];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one leaving in the same cycle
			if (fin_go) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					if (clr_q == IDX_W'(NUM_REGIONS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (take) begin
						if (!hit_c || (item.mode == MODE_CLR)) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_TRIP;
				ST_TRIP: state_q <= ST_MUL;
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					mode_q  <= item.mode;
					hit_q   <= hit_c;
					idx_q   <= idx_c;
					n_q     <= n_c;
					tot_q   <= tot_c;
					nc_q    <= nc_c;
					qz_q    <= (tot_c == '0);
					qs_q    <= (s_c >= {1'b0, tot_c});
					r_q     <= s_c[CNT_W-1:0];
					alpha_q <= '0;
					prod_q  <= '0;
					cnt_q   <= STEP_W'(DIV_STEPS - 1);
				end
			end
			ST_DIV: begin
				r_q     <= ge_c ? rsub_c[CNT_W-1:0] : r2_c[CNT_W-1:0];
				alpha_q <= {alpha_q[ALPHA_FRAC-2:0], qbit_c};
				prod_q  <= {prod_q[PROD_W-2:0], 1'b0}
					+ (qbit_c ? {{(PROD_W-CNT_W){1'b0}}, n_q} : '0);
				cnt_q   <= cnt_q - 1'b1;
			end
			ST_PREP: begin
				a_q[0]  <= mag_c;
				b_q[0]  <= mag_c;
				a_q[1]  <= prod_q;
				b_q[1]  <= {{(PROD_W-ALPHA_FRAC-1){1'b0}}, beta_c};
				hi_q[0] <= '0;
				hi_q[1] <= '0;
			end
			ST_TRIP: begin
				for (int k = 0; k < 2; k++) begin
					a3_q[k] <= {2'b00, a_q[k]} + {1'b0, a_q[k], 1'b0};
				end
				cnt_q <= STEP_W'(MUL_STEPS - 1);
			end
			ST_MUL: begin
				for (int k = 0; k < 2; k++) begin
					hi_q[k] <= step_c[k][PROD_W+1:2];
					lo_q[k] <= {step_c[k][1:0], lo_q[k][PROD_W-1:2]};
					b_q[k]  <= {2'b00, b_q[k][PROD_W-1:2]};
				end
				cnt_q <= cnt_q - 1'b1;
			end
			ST_SUM: begin
				term_q <= $signed({2'b00, sq_c}) - $signed({2'b00, var_c});
			end
			ST_FIN: begin
				if (out_free) begin
					if (hit_q && (mode_q == MODE_ACC)) begin
						result_q.region_statistic <= next_c;
						result_q.saturated        <= sat_c;
					end else begin
						result_q.region_statistic <= '0;
						result_q.saturated        <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside write-back");

	a_store_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLR) || (state_q == ST_FIN))
		else $error("store written outside sweep or write-back");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.saturated) |->
			(result_q.region_statistic == STAT_MAX) || (result_q.region_statistic == STAT_MIN))
		else $error("saturated flag without a clipped value");

	a_zero_total_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) && (tot_q == '0) |-> (alpha_q == '0) && (prod_q == '0))
		else $error("alpha non-zero for a zero allele total");

	a_mul_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> ((hi_q[0] < a_q[0]) || (hi_q[0] == '0))
			&& ((hi_q[1] < a_q[1]) || (hi_q[1] == '0)))
		else $error("serial multiplier partial product out of range");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the C-alpha region accumulator core.
module testbench
	import caracc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          NREG        = 1024;
	localparam logic [63:0] MAX_CNT     = 64'd131072;
	localparam logic [63:0] ALPHA_ONE   = 64'd1 << ALPHA_FRAC;
	localparam int          RANDOM_WORDS = 1580;
	localparam int          SAT_REGION  = 777;
	localparam int          SAT_WORDS   = 198;    // a full-size term every word, well short of clipping
	localparam int          HOLD_AFTER  = 300;    // results taken before the long receiver hold
	localparam int          HOLD_CYCLES = 400;
	localparam int          TAIL_CYCLES = 64;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_word_t  item;
	logic      result_valid;
	logic      result_stall;
	out_word_t result;

	// Scoreboard state: one running sum per region, expected results in order
	logic signed [STAT_W-1:0] region_sum [1:NREG];
	out_word_t                stat_expect [$];
	int                       faults;
	int                       results_taken;
	bit                       quiet;          // no idling on either side
	bit                       long_hold_done;

	// One directed row: the word, and the result where it is obvious at a glance
	typedef struct {
		in_word_t                 w;
		bit                       typed;
		logic signed [STAT_W-1:0] stat;
	} plan_row_t;

	plan_row_t plan [$];

	c_alpha_region_accumulator_core #(
		.NUM_REGIONS(NREG),
		.MAX_ALLELES(131072)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop, well past the slowest legal run
	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [63:0] clamp_count(logic [CNT_W-1:0] c);
		return (c > MAX_CNT) ? MAX_CNT : {46'd0, c};
	endfunction

	// Bit-exact update of the region store; returns the result word the block owes
	function automatic out_word_t c_alpha_update(in_word_t w);
		logic [63:0]              n, tot, nc, mc, alpha, num, prod, mag;
		logic [127:0]             wide;
		logic signed [STAT_W-1:0] sq, var_q16, term, acc;
		logic signed [STAT_W:0]   sum;
		out_word_t                r;
		int                       idx;
		r   = '0;
		idx = int'(w.region);
		if (idx == 0 || idx > NREG)
			return r;
		if (w.mode == MODE_CLR) begin
			region_sum[idx] = '0;
			return r;
		end
		n   = clamp_count(w.minor_total);
		tot = clamp_count(w.allele_total);
		nc  = clamp_count(w.group_minor);
		mc  = clamp_count(w.group_other);
		// alpha in units of 2^-24, zero for an empty variant, pinned just under one
		alpha = '0;
		if (tot != 0) begin
			alpha = ((nc + mc) << ALPHA_FRAC) / tot;
			if (alpha > ALPHA_ONE - 1)
				alpha = ALPHA_ONE - 1;
		end
		num  = nc << ALPHA_FRAC;
		prod = n * alpha;
		mag  = (num >= prod) ? num - prod : prod - num;
		wide = {64'd0, mag} * {64'd0, mag};
		sq   = wide[95:32];
		wide = {64'd0, prod} * {64'd0, ALPHA_ONE - alpha};
		var_q16 = wide[95:32];
		term = sq - var_q16;
		acc  = region_sum[idx];
		sum  = {acc[STAT_W-1], acc} + {term[STAT_W-1], term};
		if (!sum[STAT_W] && sum[STAT_W-1]) begin
			r.region_statistic = STAT_MAX;
			r.saturated        = 1'b1;
		end else if (sum[STAT_W] && !sum[STAT_W-1]) begin
			r.region_statistic = STAT_MIN;
			r.saturated        = 1'b1;
		end else begin
			r.region_statistic = sum[STAT_W-1:0];
		end
		region_sum[idx] = r.region_statistic;
		return r;
	endfunction

	function automatic in_word_t make_word(logic m, int unsigned reg_no, int unsigned n,
			int unsigned tot, int unsigned nc, int unsigned mc);
		in_word_t w;
		w.mode         = m;
		w.region       = reg_no[REGION_W-1:0];
		w.minor_total  = n[CNT_W-1:0];
		w.allele_total = tot[CNT_W-1:0];
		w.group_minor  = nc[CNT_W-1:0];
		w.group_other  = mc[CNT_W-1:0];
		return w;
	endfunction

	function automatic void add_row(logic m, int unsigned reg_no, int unsigned n,
			int unsigned tot, int unsigned nc, int unsigned mc, bit typed,
			logic signed [STAT_W-1:0] stat);
		plan_row_t p;
		p.w     = make_word(m, reg_no, n, tot, nc, mc);
		p.typed = typed;
		p.stat  = stat;
		plan.push_back(p);
	endfunction

	// Counts around the clamp point and the field limits
	function automatic logic [CNT_W-1:0] extreme_count();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return CNT_W'(1);
			2:       return CNT_W'(MAX_CNT - 1);
			3:       return CNT_W'(MAX_CNT);
			4:       return CNT_W'(MAX_CNT + 1);
			default: return '1;
		endcase
	endfunction

	function automatic in_word_t random_word();
		in_word_t    w;
		int unsigned pick, t;
		w.mode = ($urandom_range(0, 19) == 0) ? MODE_CLR : MODE_ACC;
		pick = $urandom_range(0, 99);
		// most words go to a few hot regions, so sums build up and clears bite
		if (pick < 4)
			w.region = REGION_W'($urandom_range(0, 2047));
		else if (pick < 60)
			w.region = REGION_W'($urandom_range(1, 8));
		else
			w.region = REGION_W'($urandom_range(1, NREG));
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			// consistent counts: group alleles and minor total within the variant total
			t = $urandom_range(0, (pick < 35) ? 200 : int'(MAX_CNT));
			w.allele_total = CNT_W'(t);
			w.group_minor  = CNT_W'($urandom_range(0, t));
			w.group_other  = CNT_W'($urandom_range(0, t - w.group_minor));
			w.minor_total  = CNT_W'($urandom_range(0, t));
		end else if (pick < 85) begin
			w.minor_total  = CNT_W'($urandom());
			w.allele_total = CNT_W'($urandom());
			w.group_minor  = CNT_W'($urandom());
			w.group_other  = CNT_W'($urandom());
		end else begin
			w.minor_total  = extreme_count();
			w.allele_total = extreme_count();
			w.group_minor  = extreme_count();
			w.group_other  = extreme_count();
		end
		return w;
	endfunction

	// Offer one word; returns at the edge where it is taken
	task automatic send_word(in_word_t w);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (stat_expect.size() != 0) @(posedge clk);
	endtask

	// Sender: directed table, random words, then a run of full-size terms with no gaps
	initial begin
		out_word_t r;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		quiet      = 1'b0;
		faults     = 0;
		for (int i = 1; i <= NREG; i++) region_sum[i] = '0;

		//      mode      region n       total   nc      mc      typed stat
		add_row(MODE_ACC, 1,     0,      0,      0,      0,      1, 0);            // fresh store reads zero
		add_row(MODE_ACC, 0,     131072, 131072, 131072, 131072, 1, 0);            // region below range
		add_row(MODE_ACC, 1025,  5,      10,     3,      4,      1, 0);            // region above range
		add_row(MODE_ACC, 2047,  'h3FFFF,'h3FFFF,'h3FFFF,'h3FFFF,1, 0);            // all ones, off the end
		add_row(MODE_ACC, 1024,  0,      0,      131072, 0,      1, 64'sh4_0000_0000_0000);
		add_row(MODE_CLR, 1024,  0,      0,      0,      0,      1, 0);
		add_row(MODE_ACC, 1024,  0,      0,      0,      0,      1, 0);            // cleared entry stays zero
		add_row(MODE_CLR, 0,     0,      0,      0,      0,      1, 0);
		add_row(MODE_CLR, 2047,  0,      0,      0,      0,      1, 0);
		add_row(MODE_ACC, 3,     100,    200,    50,     50,     1, -64'sd1638400); // pure variance term
		add_row(MODE_ACC, 4,     7,      50,     100,    100,    0, 0);            // alpha above one
		add_row(MODE_ACC, 4,     30,     30,     10,     20,     0, 0);            // alpha exactly one
		add_row(MODE_ACC, 2,     'h3FFFF,'h3FFFF,'h3FFFF,'h3FFFF,0, 0);            // every count clamped
		add_row(MODE_ACC, 2,     131073, 131073, 131073, 1,      0, 0);
		add_row(MODE_ACC, 5,     131072, 131072, 1,      0,      0, 0);            // tiny alpha, full n
		add_row(MODE_ACC, 512,   131072, 131072, 131072, 0,      0, 0);            // alpha pinned, n at max
		add_row(MODE_ACC, 6,     40,     200,    5,      15,     0, 0);
		add_row(MODE_ACC, 6,     40,     200,    35,     0,      0, 0);
		add_row(MODE_ACC, 6,     0,      1,      0,      1,      0, 0);
		add_row(MODE_CLR, 6,     9,      9,      9,      9,      1, 0);
		add_row(MODE_ACC, 6,     1,      2,      1,      0,      0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			send_word(plan[i].w);
			r = c_alpha_update(plan[i].w);
			if (plan[i].typed) begin
				r.region_statistic = plan[i].stat;
				r.saturated        = 1'b0;
			end
			stat_expect.push_back(r);
		end
		drain();

		for (int k = 0; k < RANDOM_WORDS; k++) begin
			in_word_t w;
			w = random_word();
			send_word(w);
			stat_expect.push_back(c_alpha_update(w));
			// sender holds back once until the block has handed over everything
			if (k == RANDOM_WORDS / 2)
				drain();
		end

		// Last stretch: no idling; pile full-size terms into one region
		quiet = 1'b1;
		for (int k = 0; k < SAT_WORDS + 2; k++) begin
			in_word_t w;
			if (k == 0 || k == SAT_WORDS + 1)
				w = make_word(MODE_CLR, SAT_REGION, 0, 0, 0, 0);
			else
				w = make_word(MODE_ACC, SAT_REGION, 0, 0, 131072, 0);
			send_word(w);
			stat_expect.push_back(c_alpha_update(w));
		end
		item_valid <= 1'b0;

		while (stat_expect.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (faults == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off, none in the last stretch
	initial begin
		result_stall   = 1'b0;
		long_hold_done = 1'b0;
		@(posedge clk);
		forever begin
			if (!long_hold_done && results_taken >= HOLD_AFTER) begin
				// block fills up behind its output register and stalls the sender
				long_hold_done = 1'b1;
				result_stall  <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Result check against the oldest outstanding expectation
	initial results_taken = 0;

	always @(posedge clk) begin
		out_word_t e;
		if (result_valid === 1'b1 && result_stall === 1'b0) begin
			results_taken++;
			if (stat_expect.size() == 0) begin
				$error("unexpected result word: region_statistic %0d saturated %0d",
					result.region_statistic, result.saturated);
				faults++;
			end else begin
				e = stat_expect.pop_front();
				if (result.region_statistic !== e.region_statistic) begin
					$error("region_statistic: expected %0d, got %0d",
						e.region_statistic, result.region_statistic);
					faults++;
				end
				if (result.saturated !== e.saturated) begin
					$error("saturated: expected %0d, got %0d", e.saturated, result.saturated);
					faults++;
				end
			end
		end
	end

endmodule

@@ filelist.f @@
src/caracc_pkg.sv
src/c_alpha_region_accumulator_core.sv
verif/testbench.sv
